>>> sv/mm4d_pkg.sv
package mm4d_pkg;

	localparam int ELEM_WIDTH = 16;
	localparam int FRAC_BITS  = 8;
	localparam int DET_WIDTH  = 64;
	localparam int OP_WIDTH   = 3;
	localparam int COL_WIDTH  = 2;

	localparam logic [OP_WIDTH-1:0] OP_LOAD  = 3'd0;
	localparam logic [OP_WIDTH-1:0] OP_MUL   = 3'd1;
	localparam logic [OP_WIDTH-1:0] OP_IDENT = 3'd2;
	localparam logic [OP_WIDTH-1:0] OP_ZERO  = 3'd3;
	localparam logic [OP_WIDTH-1:0] OP_DET   = 3'd4;
	localparam logic [OP_WIDTH-1:0] OP_READ  = 3'd5;

endpackage

>>> sv/matrix4_multiply_determinant.sv
// 4x4 fixed-point matrix unit. Holds one matrix in column order (signed
// Q8.8 by default) and takes one operation per transfer: load a column,
// multiply the held matrix by an rhs column, set identity, set zero, read
// the exact determinant (Q32.32, saturated) or read a column back. Each
// transfer in yields exactly one transfer out; fields with no meaning for
// the operation are zero. Multiply products are shifted right by FRAC_BITS
// (toward minus infinity) and clipped to the element width, with saturated
// set on any clip. Product columns are staged and replace the held matrix
// when rhs column 3 is multiplied. Each operation passes through the three
// pipeline stages of the four row lanes and the combinational merge into the
// result register; the next item is taken in the cycle after the result has
// moved into the output register, so a new item is not taken while one is
// still in flight. Reset clears the held matrix.
module matrix4_multiply_determinant #(
	parameter int ELEM_WIDTH = mm4d_pkg::ELEM_WIDTH,
	parameter int FRAC_BITS  = mm4d_pkg::FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [mm4d_pkg::OP_WIDTH-1:0]         opcode,
	input  logic [mm4d_pkg::COL_WIDTH-1:0]        column_index,
	input  logic signed [ELEM_WIDTH-1:0]          elem_x,
	input  logic signed [ELEM_WIDTH-1:0]          elem_y,
	input  logic signed [ELEM_WIDTH-1:0]          elem_z,
	input  logic signed [ELEM_WIDTH-1:0]          elem_w,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ELEM_WIDTH-1:0]          res_x,
	output logic signed [ELEM_WIDTH-1:0]          res_y,
	output logic signed [ELEM_WIDTH-1:0]          res_z,
	output logic signed [ELEM_WIDTH-1:0]          res_w,
	output logic signed [mm4d_pkg::DET_WIDTH-1:0] det_value,
	output logic                                  saturated
);

	localparam int EW = ELEM_WIDTH;
	localparam int LW = 4 * EW + 4;
	localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;
	localparam logic [mm4d_pkg::COL_WIDTH-1:0] LAST_COL = '1;
	localparam logic [1:0] LAST_CNT = '1;

	// control
	logic       busy_q;
	logic [1:0] cnt_q;
	logic       out_valid_q;
	logic       accept;
	logic       done;

	// captured item
	logic [mm4d_pkg::OP_WIDTH-1:0]  op_q;
	logic [mm4d_pkg::COL_WIDTH-1:0] col_q;
	logic signed [EW-1:0]           rhs_q [4];

	// matrix state, indexed [column][row]
	logic signed [EW-1:0] held_q [4][4];
	logic signed [EW-1:0] pend_q [4][4];

	// lanes and merge
	logic signed [LW-1:0] lane_s3 [4];
	logic signed [EW-1:0] m_res [4];
	logic signed [mm4d_pkg::DET_WIDTH-1:0] m_det;
	logic                 m_sat;
	logic                 det_mode;

	// result register
	logic signed [EW-1:0] res_q [4];
	logic signed [mm4d_pkg::DET_WIDTH-1:0] det_q;
	logic                 sat_q;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	// finish once the lanes have settled and the output register is free
	assign done     = busy_q && (cnt_q == LAST_CNT) && (!out_valid_q || !out_stall);
	assign det_mode = (op_q == mm4d_pkg::OP_DET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (busy_q && cnt_q != LAST_CNT) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the operands for the whole run; the lanes recompute from them
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			col_q <= column_index;
			rhs_q[0] <= elem_x;
			rhs_q[1] <= elem_y;
			rhs_q[2] <= elem_z;
			rhs_q[3] <= elem_w;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		mm4d_lane #(
			.EW   (EW),
			.LANE (g)
		) u_lane (
			.clk      (clk),
			.det_mode (det_mode),
			.held     (held_q),
			.rhs      (rhs_q),
			.lane_s3  (lane_s3[g])
		);
	end

	mm4d_merge #(
		.EW   (EW),
		.FRAC (FRAC_BITS)
	) u_merge (
		.op     (op_q),
		.lane   (lane_s3),
		.rd_col (held_q[col_q]),
		.res    (m_res),
		.det    (m_det),
		.sat    (m_sat)
	);

	// matrix updates land when the item finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					held_q[c][r] <= '0;
		end else if (done) begin
			case (op_q)
				mm4d_pkg::OP_LOAD: begin
					held_q[col_q] <= rhs_q;
				end
				mm4d_pkg::OP_MUL: begin
					// commit all staged columns after the last rhs column
					if (col_q == LAST_COL) begin
						for (int c = 0; c < 3; c++)
							held_q[c] <= pend_q[c];
						held_q[3] <= m_res;
					end
				end
				mm4d_pkg::OP_IDENT: begin
					for (int c = 0; c < 4; c++)
						for (int r = 0; r < 4; r++)
							held_q[c][r] <= (c == r) ? ONE : '0;
				end
				mm4d_pkg::OP_ZERO: begin
					for (int c = 0; c < 4; c++)
						for (int r = 0; r < 4; r++)
							held_q[c][r] <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done && op_q == mm4d_pkg::OP_MUL)
			pend_q[col_q] <= m_res;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= m_res;
			det_q <= m_det;
			sat_q <= m_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign res_x     = res_q[0];
	assign res_y     = res_q[1];
	assign res_z     = res_q[2];
	assign res_w     = res_q[3];
	assign det_value = det_q;
	assign saturated = sat_q;

endmodule

>>> sv/mm4d_lane.sv
// One lane: a dot product row for multiply, one cofactor term for determinant.
module mm4d_lane #(
	parameter int EW   = mm4d_pkg::ELEM_WIDTH,
	parameter int LANE = 0
) (
	input  logic                   clk,
	input  logic                   det_mode,
	input  logic signed [EW-1:0]   held [4][4],
	input  logic signed [EW-1:0]   rhs [4],
	output logic signed [4*EW+3:0] lane_s3
);

	localparam int PW = 2 * EW;
	localparam int TW = 4 * EW + 1;
	localparam int LW = 4 * EW + 4;
	localparam int CA = (LANE == 0) ? 1 : 0;
	localparam int CB = (LANE <= 1) ? 2 : 1;
	localparam int CC = (LANE <= 2) ? 3 : 2;
	localparam bit ODD = (LANE % 2) == 1;

	logic signed [EW-1:0] pa [4];
	logic signed [EW-1:0] pb [4];
	logic signed [PW-1:0] p_s1 [6];
	logic signed [PW-1:0] q_s1 [3];
	logic signed [PW:0]   mn [3];
	logic signed [PW+1:0] dot;
	logic signed [TW-1:0] t_s2 [3];
	logic signed [LW-1:0] v;

	// share the first four multipliers between the two modes
	always_comb begin
		if (det_mode) begin
			pa[0] = held[2][CB]; pb[0] = held[3][CC];
			pa[1] = held[2][CC]; pb[1] = held[3][CB];
			pa[2] = held[2][CA]; pb[2] = held[3][CC];
			pa[3] = held[2][CC]; pb[3] = held[3][CA];
		end else begin
			for (int k = 0; k < 4; k++) begin
				pa[k] = held[k][LANE];
				pb[k] = rhs[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++)
			p_s1[k] <= PW'(pa[k]) * PW'(pb[k]);
		p_s1[4] <= PW'(held[2][CA]) * PW'(held[3][CB]);
		p_s1[5] <= PW'(held[2][CB]) * PW'(held[3][CA]);
		q_s1[0] <= PW'(held[0][LANE]) * PW'(held[1][CA]);
		q_s1[1] <= PW'(held[0][LANE]) * PW'(held[1][CB]);
		q_s1[2] <= PW'(held[0][LANE]) * PW'(held[1][CC]);
	end

	always_comb begin
		mn[0] = (PW+1)'(p_s1[0]) - (PW+1)'(p_s1[1]);
		mn[1] = (PW+1)'(p_s1[2]) - (PW+1)'(p_s1[3]);
		mn[2] = (PW+1)'(p_s1[4]) - (PW+1)'(p_s1[5]);
		dot = (PW+2)'(p_s1[0]) + (PW+2)'(p_s1[1]) + (PW+2)'(p_s1[2]) + (PW+2)'(p_s1[3]);
	end

	always_ff @(posedge clk) begin
		if (det_mode) begin
			for (int j = 0; j < 3; j++)
				t_s2[j] <= TW'(mn[j]) * TW'(q_s1[j]);
		end else begin
			t_s2[0] <= TW'(dot);
			t_s2[1] <= '0;
			t_s2[2] <= '0;
		end
	end

	assign v = LW'(t_s2[0]) - LW'(t_s2[1]) + LW'(t_s2[2]);

	// odd rows of the first column enter the expansion negated
	always_ff @(posedge clk) begin
		lane_s3 <= (det_mode && ODD) ? -v : v;
	end

endmodule

>>> sv/mm4d_merge.sv
// Combine lane results: determinant sum or per-row shift and clip.
module mm4d_merge #(
	parameter int EW   = mm4d_pkg::ELEM_WIDTH,
	parameter int FRAC = mm4d_pkg::FRAC_BITS
) (
	input  logic [mm4d_pkg::OP_WIDTH-1:0]         op,
	input  logic signed [4*EW+3:0]                lane [4],
	input  logic signed [EW-1:0]                  rd_col [4],
	output logic signed [EW-1:0]                  res [4],
	output logic signed [mm4d_pkg::DET_WIDTH-1:0] det,
	output logic                                  sat
);

	localparam int LW   = 4 * EW + 4;
	localparam int SUMW = (LW + 2 > mm4d_pkg::DET_WIDTH + 1) ? LW + 2 : mm4d_pkg::DET_WIDTH + 1;
	localparam logic signed [SUMW-1:0] DMAX =
		SUMW'($signed({1'b0, {(mm4d_pkg::DET_WIDTH-1){1'b1}}}));
	localparam logic signed [SUMW-1:0] DMIN =
		SUMW'($signed({1'b1, {(mm4d_pkg::DET_WIDTH-1){1'b0}}}));
	localparam logic signed [LW-1:0] EMAX = LW'($signed({1'b0, {(EW-1){1'b1}}}));
	localparam logic signed [LW-1:0] EMIN = LW'($signed({1'b1, {(EW-1){1'b0}}}));

	logic signed [SUMW-1:0] sum;
	logic signed [LW-1:0]   sh [4];
	logic signed [EW-1:0]   mres [4];
	logic [3:0]             mclip;
	logic signed [mm4d_pkg::DET_WIDTH-1:0] dsat;
	logic                   dclip;

	always_comb begin
		sum = SUMW'(lane[0]) + SUMW'(lane[1]) + SUMW'(lane[2]) + SUMW'(lane[3]);
		dclip = 1'b0;
		dsat = sum[mm4d_pkg::DET_WIDTH-1:0];
		if (sum > DMAX) begin
			dsat = DMAX[mm4d_pkg::DET_WIDTH-1:0];
			dclip = 1'b1;
		end else if (sum < DMIN) begin
			dsat = DMIN[mm4d_pkg::DET_WIDTH-1:0];
			dclip = 1'b1;
		end
		for (int i = 0; i < 4; i++) begin
			sh[i] = lane[i] >>> FRAC;
			mclip[i] = 1'b1;
			if (sh[i] > EMAX)
				mres[i] = EMAX[EW-1:0];
			else if (sh[i] < EMIN)
				mres[i] = EMIN[EW-1:0];
			else begin
				mres[i] = sh[i][EW-1:0];
				mclip[i] = 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			res[i] = '0;
		det = '0;
		sat = 1'b0;
		case (op)
			mm4d_pkg::OP_MUL: begin
				res = mres;
				sat = |mclip;
			end
			mm4d_pkg::OP_DET: begin
				det = dsat;
				sat = dclip;
			end
			mm4d_pkg::OP_READ: begin
				res = rd_col;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> tb/sv/matrix4_multiply_determinant_test.sv
`timescale 1ns / 100ps

module matrix4_multiply_determinant_test;

	localparam int RANDOM_ITEMS = 1800;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [mm4d_pkg::OP_WIDTH-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [mm4d_pkg::OP_WIDTH-1:0] OP_SPARE_HI = 3'd7;

	typedef logic signed [mm4d_pkg::ELEM_WIDTH-1:0] elem_t;

	typedef struct packed {
		elem_t x, y, z, w;
		logic signed [mm4d_pkg::DET_WIDTH-1:0] det;
		logic sat;
	} mat_result_t;

	// Keeps its own copy of the held and staged matrices; predicts each result
	// when the input transfer is accepted and queues it for the output side.
	class matrix_scoreboard;
		longint held[4][4];
		longint staged[4][4];
		mat_result_t pending[$];
		int errors;

		function new();
			foreach (held[c, r]) begin
				held[c][r] = 0;
				staged[c][r] = 0;
			end
			errors = 0;
		endfunction

		// Floor shift of a 64-bit signed value.
		function longint floor_shift(longint v, int s);
			floor_shift = v >>> s;
		endfunction

		// 3x3 minor over columns 1..3, rows a, b, c; held is [column][row].
		function longint minor3(int a, int b, int c);
			minor3 = held[1][a] * (held[2][b] * held[3][c] - held[2][c] * held[3][b])
				- held[1][b] * (held[2][a] * held[3][c] - held[2][c] * held[3][a])
				+ held[1][c] * (held[2][a] * held[3][b] - held[2][b] * held[3][a]);
		endfunction

		function void note_input(logic [mm4d_pkg::OP_WIDTH-1:0] op, logic [1:0] col,
				elem_t ex, elem_t ey, elem_t ez, elem_t ew);
			longint e[4];
			longint acc, v, cof, el, hi, lo, sum_hi, sum_lo, carry, low, top;
			mat_result_t res;
			int rows[4][3];
			e[0] = ex; e[1] = ey; e[2] = ez; e[3] = ew;
			res = '0;
			rows = '{'{1, 2, 3}, '{0, 2, 3}, '{0, 1, 3}, '{0, 1, 2}};
			case (op)
				mm4d_pkg::OP_LOAD: begin
					for (int i = 0; i < 4; i++) held[col][i] = e[i];
				end
				mm4d_pkg::OP_MUL: begin
					for (int i = 0; i < 4; i++) begin
						acc = 0;
						for (int k = 0; k < 4; k++) acc += held[k][i] * e[k];
						v = floor_shift(acc, mm4d_pkg::FRAC_BITS);
						if (v > 32767) begin v = 32767; res.sat = 1'b1; end
						if (v < -32768) begin v = -32768; res.sat = 1'b1; end
						staged[col][i] = v;
						case (i)
							0: res.x = elem_t'(v);
							1: res.y = elem_t'(v);
							2: res.z = elem_t'(v);
							default: res.w = elem_t'(v);
						endcase
					end
					// commit all staged columns on rhs column 3
					if (col == 2'd3) held = staged;
				end
				mm4d_pkg::OP_IDENT: begin
					foreach (held[c, r])
						held[c][r] = (c == r) ? (longint'(1) << mm4d_pkg::FRAC_BITS) : 0;
				end
				mm4d_pkg::OP_ZERO: begin
					foreach (held[c, r]) held[c][r] = 0;
				end
				mm4d_pkg::OP_DET: begin
					// split each cofactor in high and low 32-bit halves to stay exact
					sum_hi = 0;
					sum_lo = 0;
					for (int r = 0; r < 4; r++) begin
						cof = minor3(rows[r][0], rows[r][1], rows[r][2]);
						el = (r % 2) ? -held[0][r] : held[0][r];
						hi = floor_shift(cof, 32);
						lo = cof - (hi <<< 32);
						sum_hi += el * hi;
						sum_lo += el * lo;
					end
					carry = floor_shift(sum_lo, 32);
					low = sum_lo - (carry <<< 32);
					top = sum_hi + carry;
					if (top > 64'sh7fffffff) begin
						res.det = 64'sh7fffffffffffffff;
						res.sat = 1'b1;
					end else if (top < -64'sh80000000) begin
						res.det = 64'sh8000000000000000;
						res.sat = 1'b1;
					end else begin
						res.det = (top <<< 32) + low;
					end
				end
				mm4d_pkg::OP_READ: begin
					res.x = elem_t'(held[col][0]);
					res.y = elem_t'(held[col][1]);
					res.z = elem_t'(held[col][2]);
					res.w = elem_t'(held[col][3]);
				end
				default: ;
			endcase
			pending.push_back(res);
		endfunction

		function void check_result(mat_result_t got);
			mat_result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.x !== want.x) begin $error("res_x exp %0d got %0d", want.x, got.x); errors++; end
			if (got.y !== want.y) begin $error("res_y exp %0d got %0d", want.y, got.y); errors++; end
			if (got.z !== want.z) begin $error("res_z exp %0d got %0d", want.z, got.z); errors++; end
			if (got.w !== want.w) begin $error("res_w exp %0d got %0d", want.w, got.w); errors++; end
			if (got.det !== want.det) begin
				$error("det_value exp %0d got %0d", want.det, got.det);
				errors++;
			end
			if (got.sat !== want.sat) begin
				$error("saturated exp %0b got %0b", want.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [mm4d_pkg::OP_WIDTH-1:0] opcode = '0;
	logic [mm4d_pkg::COL_WIDTH-1:0] column_index = '0;
	elem_t elem_x = '0, elem_y = '0, elem_z = '0, elem_w = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	elem_t res_x, res_y, res_z, res_w;
	logic signed [mm4d_pkg::DET_WIDTH-1:0] det_value;
	logic saturated;

	matrix_scoreboard board;
	longint cycles = 0;
	int stall_mode = 0;

	matrix4_multiply_determinant dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .column_index(column_index),
		.elem_x(elem_x), .elem_y(elem_y), .elem_z(elem_z), .elem_w(elem_w),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_x(res_x), .res_y(res_y), .res_z(res_z), .res_w(res_w),
		.det_value(det_value), .saturated(saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every output transfer and note every input transfer, both from
	// values sampled at the edge before any driver updates them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result({res_x, res_y, res_z, res_w, det_value, saturated});
			if (in_valid && !in_stall)
				board.note_input(opcode, column_index, elem_x, elem_y, elem_z, elem_w);
		end
	end

	// Receiver stall pattern: switch between never, light, heavy and periodic.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (cycles[2:0] < 3);
		endcase
		if (cycles > CYCLE_LIMIT) begin
			$display("matrix4_multiply_determinant_test: errors");
			$finish;
		end
	end

	int burst_left = 0;

	// Present one item and hold it until the transfer; gaps fall between
	// bursts so valid may stay high straight into the next item.
	task automatic send(logic [mm4d_pkg::OP_WIDTH-1:0] op, logic [1:0] col,
			elem_t ex, elem_t ey, elem_t ez, elem_t ew);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		column_index <= col;
		elem_x <= ex; elem_y <= ey; elem_z <= ez; elem_w <= ew;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 5))
			0: rand_elem = 16'sh7fff;
			1: rand_elem = 16'sh8000;
			2: rand_elem = elem_t'($urandom_range(0, 1023)) - 16'sd512;
			default: rand_elem = elem_t'($urandom);
		endcase
	endfunction

	task automatic load_random_matrix();
		for (int c = 0; c < 4; c++)
			send(mm4d_pkg::OP_LOAD, 2'(c), rand_elem(), rand_elem(), rand_elem(),
				rand_elem());
	endtask

	// Full rhs of four columns in order, so the staged product always commits
	// with every column written.
	task automatic multiply_random();
		for (int c = 0; c < 4; c++) begin
			if ($urandom_range(0, 4) == 0)
				send(mm4d_pkg::OP_READ, 2'($urandom_range(0, 3)), rand_elem(), rand_elem(),
					rand_elem(), rand_elem());
			send(mm4d_pkg::OP_MUL, 2'(c), rand_elem(), rand_elem(), rand_elem(),
				rand_elem());
		end
	endtask

	initial begin
		int sent;
		int kind;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: determinant and read of the reset matrix, identity, zero,
		// extremes, saturation on multiply and determinant, unused opcodes.
		send(mm4d_pkg::OP_DET, 2'd0, '0, '0, '0, '0);
		send(mm4d_pkg::OP_READ, 2'd2, 16'sh7fff, '0, '0, '0);
		send(mm4d_pkg::OP_IDENT, 2'd1, 16'sh1234, '0, '0, '0);
		send(mm4d_pkg::OP_DET, 2'd0, '0, '0, '0, '0);
		send(mm4d_pkg::OP_READ, 2'd3, '0, '0, '0, '0);
		for (int c = 0; c < 4; c++)
			send(mm4d_pkg::OP_LOAD, 2'(c), 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
		send(mm4d_pkg::OP_DET, 2'd0, '0, '0, '0, '0);
		send(mm4d_pkg::OP_LOAD, 2'd1, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send(mm4d_pkg::OP_LOAD, 2'd2, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send(mm4d_pkg::OP_LOAD, 2'd3, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send(mm4d_pkg::OP_DET, 2'd0, '0, '0, '0, '0);
		for (int c = 0; c < 4; c++)
			send(mm4d_pkg::OP_MUL, 2'(c), 16'sh7fff, 16'sh8000, 16'sh7fff, 16'shffff);
		send(mm4d_pkg::OP_READ, 2'd0, '0, '0, '0, '0);
		send(OP_SPARE_LO, 2'd3, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
		send(OP_SPARE_HI, 2'd0, '0, '0, '0, '0);
		send(mm4d_pkg::OP_ZERO, 2'd0, '0, '0, '0, '0);
		send(mm4d_pkg::OP_DET, 2'd0, '0, '0, '0, '0);

		// Let everything come back before the random part.
		drain();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 19);
			if (kind < 6) begin
				load_random_matrix();
				send(mm4d_pkg::OP_DET, 2'd0, '0, '0, '0, '0);
				sent += 5;
			end else if (kind < 12) begin
				multiply_random();
				send(mm4d_pkg::OP_DET, 2'd0, '0, '0, '0, '0);
				sent += 5;
			end else if (kind < 14) begin
				send($urandom_range(0, 1) ? mm4d_pkg::OP_IDENT : mm4d_pkg::OP_ZERO,
					2'($urandom), rand_elem(), rand_elem(), rand_elem(), rand_elem());
				sent++;
			end else if (kind < 18) begin
				send($urandom_range(0, 1) ? mm4d_pkg::OP_DET : mm4d_pkg::OP_READ,
					2'($urandom), rand_elem(), rand_elem(), rand_elem(), rand_elem());
				sent++;
			end else if (kind < 19) begin
				send($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI, 2'($urandom),
					rand_elem(), rand_elem(), rand_elem(), rand_elem());
				sent++;
			end else begin
				drain();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("matrix4_multiply_determinant_test: clean");
		else
			$display("matrix4_multiply_determinant_test: errors");
		$finish;
	end

endmodule

>>> matrix4_multiply_determinant.f
sv/mm4d_pkg.sv
sv/mm4d_lane.sv
sv/mm4d_merge.sv
sv/matrix4_multiply_determinant.sv
tb/sv/matrix4_multiply_determinant_test.sv
